// ----- src/smtpcs_pkg.sv -----
// SMTP client sequencer: shared types, protocol state codes, command codes and
// reply codes. No dependencies; used by every other file of the block.

package smtpcs_pkg;

  // Operation carried in the input tuser
  localparam logic [1:0] OP_REPLY   = 2'd0;
  localparam logic [1:0] OP_CONNECT = 2'd1;
  localparam logic [1:0] OP_CLOSE   = 2'd2;

  // Session states, numbered in protocol order
  localparam logic [3:0] ST_CLOSED     = 4'd0;
  localparam logic [3:0] ST_INIT       = 4'd1;
  localparam logic [3:0] ST_STARTTLS   = 4'd2;
  localparam logic [3:0] ST_WAIT_TLS   = 4'd3;
  localparam logic [3:0] ST_SEND_PLAIN = 4'd4;
  localparam logic [3:0] ST_WAIT_PLAIN = 4'd5;
  localparam logic [3:0] ST_SEND_LOGIN = 4'd6;
  localparam logic [3:0] ST_WAIT_LOGIN = 4'd7;
  localparam logic [3:0] ST_WAIT_USER  = 4'd8;
  localparam logic [3:0] ST_WAIT_PASS  = 4'd9;
  localparam logic [3:0] ST_MAIL       = 4'd10;
  localparam logic [3:0] ST_RCPT       = 4'd11;
  localparam logic [3:0] ST_DATA       = 4'd12;
  localparam logic [3:0] ST_BODY       = 4'd13;
  localparam logic [3:0] ST_QUIT       = 4'd14;

  // Command codes
  localparam logic [3:0] CMD_NONE       = 4'd0;
  localparam logic [3:0] CMD_HELO       = 4'd1;
  localparam logic [3:0] CMD_AUTH_PLAIN = 4'd2;
  localparam logic [3:0] CMD_AUTH_LOGIN = 4'd3;
  localparam logic [3:0] CMD_USER       = 4'd4;
  localparam logic [3:0] CMD_PASS       = 4'd5;
  localparam logic [3:0] CMD_STARTTLS   = 4'd6;
  localparam logic [3:0] CMD_MAIL       = 4'd7;
  localparam logic [3:0] CMD_RCPT       = 4'd8;
  localparam logic [3:0] CMD_DATA       = 4'd9;
  localparam logic [3:0] CMD_BODY       = 4'd10;
  localparam logic [3:0] CMD_QUIT       = 4'd11;

  // Reply classes
  localparam logic [1:0] CLS_OTHER     = 2'd0;
  localparam logic [1:0] CLS_TRANSIENT = 2'd1;
  localparam logic [1:0] CLS_PERMANENT = 2'd2;

  // Session events
  localparam logic [2:0] EV_NONE       = 3'd0;
  localparam logic [2:0] EV_UNEXPECTED = 3'd1;
  localparam logic [2:0] EV_DONE       = 3'd2;
  localparam logic [2:0] EV_TLS_FAIL   = 3'd3;
  localparam logic [2:0] EV_CLOSED     = 3'd4;

  // Authentication methods
  localparam logic [1:0] AUTH_PLAIN = 2'd1;
  localparam logic [1:0] AUTH_LOGIN = 2'd2;

  // Configuration register indexes
  localparam logic [1:0] REG_TLS_ENABLE = 2'd0;
  localparam logic [1:0] REG_AUTH       = 2'd1;
  localparam logic [1:0] REG_RCPT_COUNT = 2'd2;

  // Server reply codes
  localparam logic [9:0] CODE_READY     = 10'd220;
  localparam logic [9:0] CODE_OK        = 10'd250;
  localparam logic [9:0] CODE_AUTH_OK   = 10'd235;
  localparam logic [9:0] CODE_AUTH_CONT = 10'd334;
  localparam logic [9:0] CODE_DATA_GO   = 10'd354;
  localparam logic [9:0] CODE_DIGIT     = 10'd100;

  typedef struct packed {
    logic       tls_enable;
    logic [1:0] auth_method;
    logic [4:0] recipient_count;
  } cfg_t;

  typedef struct packed {
    logic [1:0] operation;
    logic [9:0] response_code;
    logic       final_line;
    logic       tls_ok;
  } req_t;

  typedef struct packed {
    logic [3:0] protocol_state;
    logic [2:0] session_event;
    logic [1:0] reply_class;
    logic [3:0] recipient_number;
    logic [3:0] command;
  } rsp_t;

  // Next state once HELO is sent
  function automatic logic [3:0] after_helo(logic pend, logic [1:0] auth);
    logic [3:0] st;
    if (pend) begin
      st = ST_STARTTLS;
    end else if (auth == AUTH_PLAIN) begin
      st = ST_SEND_PLAIN;
    end else if (auth == AUTH_LOGIN) begin
      st = ST_SEND_LOGIN;
    end else begin
      st = ST_MAIL;
    end
    return st;
  endfunction

endpackage

// ----- src/smtp_client_sequencer_core.sv -----
// SMTP client sequencer top level: input register, decision logic, result register.
// Path: an accepted request waits in the input register, then its result is loaded into the
// result register and presented on m_axis. Throughput: one request per cycle while m_axis is not stalled.
// A stalled result holds in the output register while one more request waits behind it.
// Reset (rst_ni low, asynchronous): session closed, no TLS pending, recipient index
// zero, registers tls_enable 0, auth_method 0, recipient_count 1, both stages empty.

module smtp_client_sequencer_core #(
  parameter int unsigned MAX_RECIPIENTS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // request stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // [9:0] response_code, [10] tls_ok, [15:11] zero
  input  logic [1:0]  s_axis_tuser,   // [1:0] operation
  input  logic        s_axis_tlast,   // final_line
  // result stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // [3:0] command, [7:4] recipient_number,
                                      // [9:8] reply_class, [12:10] session_event,
                                      // [16:13] protocol_state, [23:17] zero
  // configuration writes
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [4:0]  cfg_data_i
);

  smtpcs_pkg::cfg_t cfg;
  smtpcs_pkg::req_t in_q, in_d;
  smtpcs_pkg::rsp_t rsp, out_q;
  logic             in_vld_q, in_vld_d;
  logic             out_vld_q, out_vld_d;
  logic             advance;
  logic             take;

  // Configuration is always accepted; the user must write it only while idle, unchecked.
  assign cfg_ready_o = 1'b1;

  smtpcs_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_en_i    (cfg_valid_i),
    .wr_index_i (cfg_index_i),
    .wr_data_i  (cfg_data_i),
    .cfg_o      (cfg)
  );

  // Advance the held request into the result register whenever that register
  // is empty or its content is being taken this cycle.
  assign advance       = in_vld_q && (!out_vld_q || m_axis_tready);
  assign s_axis_tready = !in_vld_q || advance;
  assign take          = s_axis_tvalid && s_axis_tready;

  smtpcs_fsm #(
    .MAX_RECIPIENTS (MAX_RECIPIENTS)
  ) u_fsm (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (advance),
    .cfg_i  (cfg),
    .req_i  (in_q),
    .rsp_o  (rsp)
  );

  // Unpack the request fields
  always_comb begin
    in_d.operation     = s_axis_tuser;
    in_d.response_code = s_axis_tdata[9:0];
    in_d.final_line    = s_axis_tlast;
    in_d.tls_ok        = s_axis_tdata[10];
  end

  assign in_vld_d  = take || (in_vld_q && !advance);
  assign out_vld_d = advance || (out_vld_q && !m_axis_tready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      in_vld_q  <= in_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  // Payload registers: load on handshake, hold otherwise
  always_ff @(posedge clk_i) begin
    if (take) begin
      in_q <= in_d;
    end
    if (advance) begin
      out_q <= rsp;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {7'd0, out_q};

`ifndef NO_ASSERTIONS
  // A request that advances always lands as a valid result
  a_advance_fills: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> out_vld_q)
    else $error("advanced request did not produce a result");

  // A close event always leaves the session closed
  a_close_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && out_q.session_event == smtpcs_pkg::EV_CLOSED)
      |-> out_q.protocol_state == smtpcs_pkg::ST_CLOSED)
    else $error("close event with open session");

  // QUIT completes the send
  a_quit_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && out_q.command == smtpcs_pkg::CMD_QUIT)
      |-> out_q.session_event == smtpcs_pkg::EV_DONE)
    else $error("QUIT without send-complete event");

  // RCPT leaves the session in RCPT or DATA
  a_rcpt_next: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && out_q.command == smtpcs_pkg::CMD_RCPT)
      |-> (out_q.protocol_state == smtpcs_pkg::ST_RCPT ||
           out_q.protocol_state == smtpcs_pkg::ST_DATA))
    else $error("RCPT left an unexpected state");
`endif

endmodule

// ----- src/smtpcs_cfg.sv -----
// SMTP client sequencer: configuration register file.
// Depends on smtpcs_pkg for the register indexes and cfg_t.

module smtpcs_cfg (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              wr_en_i,
  input  logic [1:0]        wr_index_i,
  input  logic [4:0]        wr_data_i,
  output smtpcs_pkg::cfg_t  cfg_o
);

  smtpcs_pkg::cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en_i) begin
      unique case (wr_index_i)
        smtpcs_pkg::REG_TLS_ENABLE: cfg_d.tls_enable      = wr_data_i[0];
        smtpcs_pkg::REG_AUTH:       cfg_d.auth_method     = wr_data_i[1:0];
        smtpcs_pkg::REG_RCPT_COUNT: cfg_d.recipient_count = wr_data_i;
        default:                    cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.tls_enable      <= 1'b0;
      cfg_q.auth_method     <= 2'd0;
      cfg_q.recipient_count <= 5'd1;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ----- src/smtpcs_fsm.sv -----
// SMTP client sequencer: session state registers and the single-pass decision
// for one request. Depends on smtpcs_pkg for codes, cfg_t, req_t and rsp_t.

module smtpcs_fsm #(
  parameter int unsigned MAX_RECIPIENTS = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              step_i,
  input  smtpcs_pkg::cfg_t  cfg_i,
  input  smtpcs_pkg::req_t  req_i,
  output smtpcs_pkg::rsp_t  rsp_o
);

  localparam int unsigned IdxW = $clog2(MAX_RECIPIENTS + 1);
  localparam int unsigned CmpW = (IdxW > 5) ? IdxW : 5;
  localparam logic [CmpW-1:0] MaxCnt = CmpW'(MAX_RECIPIENTS);

  logic [3:0]      state_q, state_d;
  logic            pend_q, pend_d;
  logic [IdxW-1:0] idx_q, idx_d;

  logic [CmpW-1:0] cnt_raw, cnt_eff, idx_next_ext;
  logic [IdxW-1:0] idx_next;
  logic [IdxW+3:0] idx_wide;
  logic            ok;
  logic [9:0]      code;
  smtpcs_pkg::rsp_t rsp;

  assign code = req_i.response_code;

  // Clamp the recipient count into 1..MAX_RECIPIENTS
  assign cnt_raw = CmpW'(cfg_i.recipient_count);
  always_comb begin
    priority if (cnt_raw == '0) begin
      cnt_eff = CmpW'(1);
    end else if (cnt_raw > MaxCnt) begin
      cnt_eff = MaxCnt;
    end else begin
      cnt_eff = cnt_raw;
    end
  end

  assign idx_next     = idx_q + IdxW'(1);
  assign idx_next_ext = CmpW'(idx_next);
  assign idx_wide     = {4'd0, idx_q};

  always_comb begin
    state_d = state_q;
    pend_d  = pend_q;
    idx_d   = idx_q;
    ok      = 1'b1;
    rsp     = '0;
    unique case (req_i.operation)
      smtpcs_pkg::OP_CONNECT: begin
        pend_d  = cfg_i.tls_enable;
        idx_d   = '0;
        state_d = smtpcs_pkg::ST_INIT;
      end
      smtpcs_pkg::OP_CLOSE: begin
        state_d           = smtpcs_pkg::ST_CLOSED;
        rsp.session_event = smtpcs_pkg::EV_CLOSED;
      end
      smtpcs_pkg::OP_REPLY: begin
        if (code >= 10'd400 && code < 10'd500) begin
          rsp.reply_class = smtpcs_pkg::CLS_TRANSIENT;
        end else if (code >= 10'd500 && code < 10'd600) begin
          rsp.reply_class = smtpcs_pkg::CLS_PERMANENT;
        end
        if (req_i.final_line && state_q != smtpcs_pkg::ST_CLOSED) begin
          unique case (state_q)
            smtpcs_pkg::ST_INIT: begin
              ok = (code == smtpcs_pkg::CODE_READY);
              rsp.command = smtpcs_pkg::CMD_HELO;
              state_d = smtpcs_pkg::after_helo(pend_q, cfg_i.auth_method);
            end
            smtpcs_pkg::ST_STARTTLS: begin
              ok = (code == smtpcs_pkg::CODE_OK);
              rsp.command = smtpcs_pkg::CMD_STARTTLS;
              state_d = smtpcs_pkg::ST_WAIT_TLS;
            end
            smtpcs_pkg::ST_WAIT_TLS: begin
              ok = (code == smtpcs_pkg::CODE_READY);
              pend_d = 1'b0;
              if (req_i.tls_ok) begin
                rsp.command = smtpcs_pkg::CMD_HELO;
                state_d = smtpcs_pkg::after_helo(1'b0, cfg_i.auth_method);
              end else begin
                rsp.session_event = smtpcs_pkg::EV_TLS_FAIL;
                state_d = smtpcs_pkg::ST_CLOSED;
              end
            end
            smtpcs_pkg::ST_SEND_PLAIN: begin
              ok = (code == smtpcs_pkg::CODE_OK);
              rsp.command = smtpcs_pkg::CMD_AUTH_PLAIN;
              state_d = smtpcs_pkg::ST_WAIT_PLAIN;
            end
            smtpcs_pkg::ST_SEND_LOGIN: begin
              ok = (code == smtpcs_pkg::CODE_OK);
              rsp.command = smtpcs_pkg::CMD_AUTH_LOGIN;
              state_d = smtpcs_pkg::ST_WAIT_LOGIN;
            end
            smtpcs_pkg::ST_WAIT_LOGIN: begin
              ok = (code == smtpcs_pkg::CODE_AUTH_CONT);
              rsp.command = smtpcs_pkg::CMD_USER;
              state_d = smtpcs_pkg::ST_WAIT_USER;
            end
            smtpcs_pkg::ST_WAIT_USER: begin
              ok = (code == smtpcs_pkg::CODE_AUTH_CONT);
              rsp.command = smtpcs_pkg::CMD_PASS;
              state_d = smtpcs_pkg::ST_WAIT_PASS;
            end
            smtpcs_pkg::ST_WAIT_PLAIN, smtpcs_pkg::ST_WAIT_PASS: begin
              // Authenticated: MAIL goes out right away
              ok = (code == smtpcs_pkg::CODE_AUTH_OK);
              idx_d = '0;
              rsp.command = smtpcs_pkg::CMD_MAIL;
              state_d = smtpcs_pkg::ST_RCPT;
            end
            smtpcs_pkg::ST_MAIL: begin
              ok = (code == smtpcs_pkg::CODE_OK);
              rsp.command = smtpcs_pkg::CMD_MAIL;
              state_d = smtpcs_pkg::ST_RCPT;
            end
            smtpcs_pkg::ST_RCPT: begin
              ok = (code == smtpcs_pkg::CODE_OK);
              rsp.command = smtpcs_pkg::CMD_RCPT;
              rsp.recipient_number = idx_wide[3:0];
              idx_d = idx_next;
              state_d = (idx_next_ext >= cnt_eff) ? smtpcs_pkg::ST_DATA
                                                  : smtpcs_pkg::ST_RCPT;
            end
            smtpcs_pkg::ST_DATA: begin
              ok = (code == smtpcs_pkg::CODE_OK);
              rsp.command = smtpcs_pkg::CMD_DATA;
              state_d = smtpcs_pkg::ST_BODY;
            end
            smtpcs_pkg::ST_BODY: begin
              ok = (code == smtpcs_pkg::CODE_DATA_GO);
              rsp.command = smtpcs_pkg::CMD_BODY;
              state_d = smtpcs_pkg::ST_QUIT;
            end
            smtpcs_pkg::ST_QUIT: begin
              ok = (code == smtpcs_pkg::CODE_OK);
              rsp.command = smtpcs_pkg::CMD_QUIT;
              rsp.session_event = smtpcs_pkg::EV_DONE;
              state_d = smtpcs_pkg::ST_CLOSED;
            end
            default: begin
              ok = 1'b0;
            end
          endcase
          // HELO with no TLS and no auth lands in the MAIL state: restart recipients
          if (ok && state_d == smtpcs_pkg::ST_MAIL) begin
            idx_d = '0;
          end
          if (!ok) begin
            // Unexpected reply: drop the command and end the session
            state_d              = smtpcs_pkg::ST_CLOSED;
            pend_d               = pend_q;
            idx_d                = idx_q;
            rsp.command          = smtpcs_pkg::CMD_NONE;
            rsp.recipient_number = 4'd0;
            rsp.session_event    = smtpcs_pkg::EV_UNEXPECTED;
          end
        end
      end
      default: begin
        state_d = state_q;
      end
    endcase
    rsp.protocol_state = state_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= smtpcs_pkg::ST_CLOSED;
      pend_q  <= 1'b0;
      idx_q   <= '0;
    end else if (step_i) begin
      state_q <= state_d;
      pend_q  <= pend_d;
      idx_q   <= idx_d;
    end
  end

  assign rsp_o = rsp;

endmodule

// ----- sim/smtp_client_sequencer_core_test.sv -----
// Self-checking bench for smtp_client_sequencer_core: a directed session table, then
// random SMTP sessions under eight register settings and four idling patterns.
// Depends on src/smtpcs_pkg.sv and src/smtp_client_sequencer_core.sv.
`timescale 1ns / 100ps

module smtp_client_sequencer_core_test;

  localparam int PERIOD      = 20;
  localparam int MAX_RCPT    = 16;
  localparam int STALL_LIMIT = 3000;   // cycles with no handshake of any kind
  localparam int PHASES      = 8;
  localparam int PHASE_ITEMS = 90;

  // Operation value that the block must ignore, and the register index with no register
  localparam logic [1:0] OP_UNUSED  = 2'd3;
  localparam logic [1:0] REG_UNUSED = 2'd3;

  // Register settings of the first six phases (extremes first); the last two are random
  localparam logic [0:5][4:0] TLS_PLAN  = {5'd1, 5'd0, 5'd1, 5'd0, 5'd1, 5'd0};
  localparam logic [0:5][4:0] AUTH_PLAN = {5'd1, 5'd2, 5'd2, 5'd0, 5'd3, 5'd1};
  localparam logic [0:5][4:0] RCPT_PLAN = {5'd16, 5'd3, 5'd31, 5'd0, 5'd17, 5'd2};

  typedef enum logic [1:0] {
    ROW_WRITE,      // register write: op holds the index, code the data
    ROW_TYPED,      // request checked against the result typed into the row
    ROW_PREDICTED   // request checked against the session predictor
  } row_kind_e;

  typedef struct packed {
    row_kind_e        kind;
    logic [1:0]       op;
    logic [9:0]       code;
    logic             last;
    logic             tls_ok;
    smtpcs_pkg::rsp_t want;
  } plan_row_t;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata  = '0;
  logic [1:0]  s_axis_tuser  = '0;
  logic        s_axis_tlast  = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;
  logic        cfg_valid_i   = 1'b0;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i   = '0;
  logic [4:0]  cfg_data_i    = '0;

  // Predictor copy of the registers and of the session
  logic        cfg_tls  = 1'b0;
  logic [1:0]  cfg_auth = 2'd0;
  logic [4:0]  cfg_rcpt = 5'd1;
  logic [3:0]  sess_state = smtpcs_pkg::ST_CLOSED;
  logic        tls_wait   = 1'b0;
  logic [15:0] rcpt_idx   = '0;

  smtpcs_pkg::rsp_t pending_rsp [$];     // results owed by the block, oldest first
  plan_row_t        plan [$];
  int unsigned      mismatches     = 0;
  int unsigned      quiet_cycles   = 0;
  int unsigned      sender_gap_pct = 0;
  int unsigned      sink_stall_pct = 0;
  smtpcs_pkg::rsp_t seen_rsp;
  smtpcs_pkg::rsp_t owed_rsp;

  smtp_client_sequencer_core #(
    .MAX_RECIPIENTS(MAX_RCPT)
  ) DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i)
  );

  always #(PERIOD / 2) clk_i = ~clk_i;

  // Stall the result stream at the rate of the current phase
  always @(negedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
  end

  // ---------------------------------------------------------------------------
  // Session predictor
  // ---------------------------------------------------------------------------

  // Recipients actually addressed: a zero count means one, and the count saturates
  function automatic logic [15:0] rcpt_limit();
    logic [15:0] n;
    n = 16'(cfg_rcpt);
    if (n == 0) n = 16'd1;
    if (n > MAX_RCPT) n = 16'(MAX_RCPT);
    return n;
  endfunction

  // Where the session goes once HELO is out: TLS first, then auth, else straight to MAIL
  function automatic logic [3:0] helo_followup();
    if (tls_wait) return smtpcs_pkg::ST_STARTTLS;
    if (cfg_auth == smtpcs_pkg::AUTH_PLAIN) return smtpcs_pkg::ST_SEND_PLAIN;
    if (cfg_auth == smtpcs_pkg::AUTH_LOGIN) return smtpcs_pkg::ST_SEND_LOGIN;
    rcpt_idx = '0;   // auth method 3 falls through here like "none"
    return smtpcs_pkg::ST_MAIL;
  endfunction

  // Advance the session by one request and return the result it owes
  function automatic smtpcs_pkg::rsp_t step_session(input smtpcs_pkg::req_t r);
    smtpcs_pkg::rsp_t o;
    logic [3:0]       nxt;
    logic             hit;
    o   = '0;
    nxt = sess_state;
    hit = 1'b1;
    case (r.operation)
      smtpcs_pkg::OP_CONNECT: begin
        // reconnect restarts the session even mid-transfer
        tls_wait = cfg_tls;
        rcpt_idx = '0;
        nxt      = smtpcs_pkg::ST_INIT;
      end
      smtpcs_pkg::OP_CLOSE: begin
        nxt             = smtpcs_pkg::ST_CLOSED;
        o.session_event = smtpcs_pkg::EV_CLOSED;
      end
      smtpcs_pkg::OP_REPLY: begin
        // class every line, partial or not, by its hundreds digit
        if (r.response_code / smtpcs_pkg::CODE_DIGIT == 10'd4) begin
          o.reply_class = smtpcs_pkg::CLS_TRANSIENT;
        end else if (r.response_code / smtpcs_pkg::CODE_DIGIT == 10'd5) begin
          o.reply_class = smtpcs_pkg::CLS_PERMANENT;
        end
        if (r.final_line && sess_state != smtpcs_pkg::ST_CLOSED) begin
          case (sess_state)
            smtpcs_pkg::ST_INIT: begin
              if (r.response_code == smtpcs_pkg::CODE_READY) begin
                o.command = smtpcs_pkg::CMD_HELO;
                nxt       = helo_followup();
              end else hit = 1'b0;
            end
            smtpcs_pkg::ST_STARTTLS: begin
              if (r.response_code == smtpcs_pkg::CODE_OK) begin
                o.command = smtpcs_pkg::CMD_STARTTLS;
                nxt       = smtpcs_pkg::ST_WAIT_TLS;
              end else hit = 1'b0;
            end
            smtpcs_pkg::ST_WAIT_TLS: begin
              if (r.response_code == smtpcs_pkg::CODE_READY) begin
                tls_wait = 1'b0;
                if (r.tls_ok) begin
                  o.command = smtpcs_pkg::CMD_HELO;
                  nxt       = helo_followup();
                end else begin
                  nxt             = smtpcs_pkg::ST_CLOSED;
                  o.session_event = smtpcs_pkg::EV_TLS_FAIL;
                end
              end else hit = 1'b0;
            end
            smtpcs_pkg::ST_SEND_PLAIN: begin
              if (r.response_code == smtpcs_pkg::CODE_OK) begin
                o.command = smtpcs_pkg::CMD_AUTH_PLAIN;
                nxt       = smtpcs_pkg::ST_WAIT_PLAIN;
              end else hit = 1'b0;
            end
            smtpcs_pkg::ST_SEND_LOGIN: begin
              if (r.response_code == smtpcs_pkg::CODE_OK) begin
                o.command = smtpcs_pkg::CMD_AUTH_LOGIN;
                nxt       = smtpcs_pkg::ST_WAIT_LOGIN;
              end else hit = 1'b0;
            end
            smtpcs_pkg::ST_WAIT_LOGIN: begin
              if (r.response_code == smtpcs_pkg::CODE_AUTH_CONT) begin
                o.command = smtpcs_pkg::CMD_USER;
                nxt       = smtpcs_pkg::ST_WAIT_USER;
              end else hit = 1'b0;
            end
            smtpcs_pkg::ST_WAIT_USER: begin
              if (r.response_code == smtpcs_pkg::CODE_AUTH_CONT) begin
                o.command = smtpcs_pkg::CMD_PASS;
                nxt       = smtpcs_pkg::ST_WAIT_PASS;
              end else hit = 1'b0;
            end
            smtpcs_pkg::ST_WAIT_PLAIN, smtpcs_pkg::ST_WAIT_PASS: begin
              // auth accepted: MAIL goes out in the same step
              if (r.response_code == smtpcs_pkg::CODE_AUTH_OK) begin
                rcpt_idx  = '0;
                o.command = smtpcs_pkg::CMD_MAIL;
                nxt       = smtpcs_pkg::ST_RCPT;
              end else hit = 1'b0;
            end
            smtpcs_pkg::ST_MAIL: begin
              if (r.response_code == smtpcs_pkg::CODE_OK) begin
                o.command = smtpcs_pkg::CMD_MAIL;
                nxt       = smtpcs_pkg::ST_RCPT;
              end else hit = 1'b0;
            end
            smtpcs_pkg::ST_RCPT: begin
              if (r.response_code == smtpcs_pkg::CODE_OK) begin
                o.command          = smtpcs_pkg::CMD_RCPT;
                o.recipient_number = rcpt_idx[3:0];
                rcpt_idx           = rcpt_idx + 1'b1;
                nxt                = (rcpt_idx >= rcpt_limit()) ? smtpcs_pkg::ST_DATA
                                                                : smtpcs_pkg::ST_RCPT;
              end else hit = 1'b0;
            end
            smtpcs_pkg::ST_DATA: begin
              if (r.response_code == smtpcs_pkg::CODE_OK) begin
                o.command = smtpcs_pkg::CMD_DATA;
                nxt       = smtpcs_pkg::ST_BODY;
              end else hit = 1'b0;
            end
            smtpcs_pkg::ST_BODY: begin
              if (r.response_code == smtpcs_pkg::CODE_DATA_GO) begin
                o.command = smtpcs_pkg::CMD_BODY;
                nxt       = smtpcs_pkg::ST_QUIT;
              end else hit = 1'b0;
            end
            smtpcs_pkg::ST_QUIT: begin
              if (r.response_code == smtpcs_pkg::CODE_OK) begin
                o.command       = smtpcs_pkg::CMD_QUIT;
                o.session_event = smtpcs_pkg::EV_DONE;
                nxt             = smtpcs_pkg::ST_CLOSED;
              end else hit = 1'b0;
            end
            default: hit = 1'b0;
          endcase
          if (!hit) begin
            o.command          = smtpcs_pkg::CMD_NONE;
            o.recipient_number = '0;
            o.session_event    = smtpcs_pkg::EV_UNEXPECTED;
            nxt                = smtpcs_pkg::ST_CLOSED;
          end
        end
      end
      default: ;   // unused operation: nothing moves
    endcase
    sess_state       = nxt;
    o.protocol_state = nxt;
    return o;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  // Reply code the server gives when things go well in a state
  function automatic logic [9:0] reply_wanted(input logic [3:0] st);
    case (st)
      smtpcs_pkg::ST_INIT, smtpcs_pkg::ST_WAIT_TLS:        return smtpcs_pkg::CODE_READY;
      smtpcs_pkg::ST_WAIT_LOGIN, smtpcs_pkg::ST_WAIT_USER: return smtpcs_pkg::CODE_AUTH_CONT;
      smtpcs_pkg::ST_WAIT_PLAIN, smtpcs_pkg::ST_WAIT_PASS: return smtpcs_pkg::CODE_AUTH_OK;
      smtpcs_pkg::ST_BODY:                                 return smtpcs_pkg::CODE_DATA_GO;
      default:                                             return smtpcs_pkg::CODE_OK;
    endcase
  endfunction

  // Mostly a well-behaved server; now and then a multi-line reply, a bad code,
  // a reconnect, a drop or garbage
  function automatic smtpcs_pkg::req_t pick_request();
    smtpcs_pkg::req_t r;
    int unsigned      roll;
    r.operation     = smtpcs_pkg::OP_REPLY;
    r.response_code = reply_wanted(sess_state);
    r.final_line    = 1'b1;
    r.tls_ok        = ($urandom_range(99) < 85);
    roll            = $urandom_range(99);
    if (sess_state == smtpcs_pkg::ST_CLOSED) begin
      if (roll < 85) r.operation = smtpcs_pkg::OP_CONNECT;
      else if (roll < 92) r.final_line = 1'($urandom_range(1));
      else if (roll < 96) r.operation = smtpcs_pkg::OP_CLOSE;
      else r.operation = OP_UNUSED;
    end else begin
      if (roll < 88) ;
      else if (roll < 95) r.final_line = 1'b0;
      else if (roll < 97) r.response_code = 10'($urandom_range(1023));
      else if (roll < 98) r.operation = smtpcs_pkg::OP_CONNECT;
      else if (roll < 99) r.operation = smtpcs_pkg::OP_CLOSE;
      else r.operation = OP_UNUSED;
    end
    // scramble fields that carry no meaning for this request
    if (r.operation != smtpcs_pkg::OP_REPLY || !r.final_line) begin
      r.response_code = 10'($urandom_range(1023));
      if (r.operation != smtpcs_pkg::OP_REPLY) r.final_line = 1'($urandom_range(1));
    end
    return r;
  endfunction

  function automatic smtpcs_pkg::rsp_t result(input logic [3:0] cmd,
                                              input logic [3:0] rnum,
                                              input logic [1:0] cls, input logic [2:0] ev,
                                              input logic [3:0] st);
    smtpcs_pkg::rsp_t o;
    o.command          = cmd;
    o.recipient_number = rnum;
    o.reply_class      = cls;
    o.session_event    = ev;
    o.protocol_state   = st;
    return o;
  endfunction

  function automatic plan_row_t row(input row_kind_e kind, input logic [1:0] op,
                                    input logic [9:0] code, input logic last,
                                    input logic tls_ok, input smtpcs_pkg::rsp_t want);
    plan_row_t p;
    p.kind   = kind;
    p.op     = op;
    p.code   = code;
    p.last   = last;
    p.tls_ok = tls_ok;
    p.want   = want;
    return p;
  endfunction

  // Offer one request after a random gap; hold tvalid high across back-to-back requests
  task automatic send_request(input smtpcs_pkg::req_t r, input bit typed,
                              input smtpcs_pkg::rsp_t typed_rsp);
    smtpcs_pkg::rsp_t p;
    @(negedge clk_i);
    while ($urandom_range(99) < sender_gap_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {5'd0, r.tls_ok, r.response_code};
    s_axis_tuser  <= r.operation;
    s_axis_tlast  <= r.final_line;
    do @(posedge clk_i); while (!s_axis_tready);
    p = step_session(r);
    pending_rsp.push_back(typed ? typed_rsp : p);
  endtask

  // Drop the request stream and hold until every owed result has come back
  task automatic drain();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (pending_rsp.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_register(input logic [1:0] idx, input logic [4:0] val);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      smtpcs_pkg::REG_TLS_ENABLE: cfg_tls  = val[0];
      smtpcs_pkg::REG_AUTH:       cfg_auth = val[1:0];
      smtpcs_pkg::REG_RCPT_COUNT: cfg_rcpt = val;
      default: ;   // no register behind this index
    endcase
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Result checking and watchdog
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
          (cfg_valid_i && cfg_ready_o)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end else if (m_axis_tvalid && m_axis_tready) begin
        seen_rsp = m_axis_tdata[16:0];
        if (pending_rsp.size() == 0) begin
          $error("result 0x%h with no request outstanding", m_axis_tdata);
          mismatches++;
        end else begin
          owed_rsp = pending_rsp.pop_front();
          check_field("command", 32'(owed_rsp.command), 32'(seen_rsp.command));
          check_field("recipient_number", 32'(owed_rsp.recipient_number),
                      32'(seen_rsp.recipient_number));
          check_field("reply_class", 32'(owed_rsp.reply_class),
                      32'(seen_rsp.reply_class));
          check_field("session_event", 32'(owed_rsp.session_event),
                      32'(seen_rsp.session_event));
          check_field("protocol_state", 32'(owed_rsp.protocol_state),
                      32'(seen_rsp.protocol_state));
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    smtpcs_pkg::req_t r;
    int unsigned      served;
    int unsigned      mode;
    smtpcs_pkg::rsp_t idle_closed;
    smtpcs_pkg::rsp_t idle_init;

    idle_closed = result(smtpcs_pkg::CMD_NONE, 4'd0, smtpcs_pkg::CLS_OTHER,
                         smtpcs_pkg::EV_NONE, smtpcs_pkg::ST_CLOSED);
    idle_init   = result(smtpcs_pkg::CMD_NONE, 4'd0, smtpcs_pkg::CLS_OTHER,
                         smtpcs_pkg::EV_NONE, smtpcs_pkg::ST_INIT);

    // Directed session table; reset registers are tls off, no auth, one recipient
    // replies while closed are only classed, including a code past 999
    plan.push_back(row(ROW_TYPED, smtpcs_pkg::OP_REPLY, smtpcs_pkg::CODE_OK, 1'b1, 1'b0,
                       idle_closed));
    plan.push_back(row(ROW_TYPED, smtpcs_pkg::OP_REPLY, 10'd1023, 1'b1, 1'b1, idle_closed));
    plan.push_back(row(ROW_TYPED, OP_UNUSED, 10'd1023, 1'b1, 1'b1, idle_closed));
    plan.push_back(row(ROW_TYPED, smtpcs_pkg::OP_CLOSE, 10'd0, 1'b0, 1'b0,
                       result(smtpcs_pkg::CMD_NONE, 4'd0, smtpcs_pkg::CLS_OTHER,
                              smtpcs_pkg::EV_CLOSED, smtpcs_pkg::ST_CLOSED)));
    plan.push_back(row(ROW_TYPED, smtpcs_pkg::OP_CONNECT, 10'd0, 1'b0, 1'b0, idle_init));
    // partial lines: class edges of 4xx and 5xx, and a partial of the right code
    plan.push_back(row(ROW_TYPED, smtpcs_pkg::OP_REPLY, 10'd400, 1'b0, 1'b0,
                       result(smtpcs_pkg::CMD_NONE, 4'd0, smtpcs_pkg::CLS_TRANSIENT,
                              smtpcs_pkg::EV_NONE, smtpcs_pkg::ST_INIT)));
    plan.push_back(row(ROW_TYPED, smtpcs_pkg::OP_REPLY, 10'd499, 1'b0, 1'b0,
                       result(smtpcs_pkg::CMD_NONE, 4'd0, smtpcs_pkg::CLS_TRANSIENT,
                              smtpcs_pkg::EV_NONE, smtpcs_pkg::ST_INIT)));
    plan.push_back(row(ROW_TYPED, smtpcs_pkg::OP_REPLY, 10'd500, 1'b0, 1'b0,
                       result(smtpcs_pkg::CMD_NONE, 4'd0, smtpcs_pkg::CLS_PERMANENT,
                              smtpcs_pkg::EV_NONE, smtpcs_pkg::ST_INIT)));
    plan.push_back(row(ROW_TYPED, smtpcs_pkg::OP_REPLY, 10'd599, 1'b0, 1'b0,
                       result(smtpcs_pkg::CMD_NONE, 4'd0, smtpcs_pkg::CLS_PERMANENT,
                              smtpcs_pkg::EV_NONE, smtpcs_pkg::ST_INIT)));
    plan.push_back(row(ROW_TYPED, smtpcs_pkg::OP_REPLY, smtpcs_pkg::CODE_READY, 1'b0, 1'b0,
                       idle_init));
    // full plain session
    plan.push_back(row(ROW_PREDICTED, smtpcs_pkg::OP_REPLY, smtpcs_pkg::CODE_READY,
                       1'b1, 1'b0, '0));
    plan.push_back(row(ROW_PREDICTED, smtpcs_pkg::OP_REPLY, smtpcs_pkg::CODE_OK,
                       1'b1, 1'b0, '0));
    plan.push_back(row(ROW_PREDICTED, smtpcs_pkg::OP_REPLY, smtpcs_pkg::CODE_OK,
                       1'b1, 1'b0, '0));
    plan.push_back(row(ROW_PREDICTED, smtpcs_pkg::OP_REPLY, smtpcs_pkg::CODE_OK,
                       1'b1, 1'b0, '0));
    plan.push_back(row(ROW_PREDICTED, smtpcs_pkg::OP_REPLY, smtpcs_pkg::CODE_DATA_GO,
                       1'b1, 1'b0, '0));
    plan.push_back(row(ROW_TYPED, smtpcs_pkg::OP_REPLY, smtpcs_pkg::CODE_OK, 1'b1, 1'b0,
                       result(smtpcs_pkg::CMD_QUIT, 4'd0, smtpcs_pkg::CLS_OTHER,
                              smtpcs_pkg::EV_DONE, smtpcs_pkg::ST_CLOSED)));
    // unexpected codes at the low and high end
    plan.push_back(row(ROW_TYPED, smtpcs_pkg::OP_CONNECT, 10'd1023, 1'b1, 1'b1, idle_init));
    plan.push_back(row(ROW_TYPED, smtpcs_pkg::OP_REPLY, 10'd0, 1'b1, 1'b0,
                       result(smtpcs_pkg::CMD_NONE, 4'd0, smtpcs_pkg::CLS_OTHER,
                              smtpcs_pkg::EV_UNEXPECTED, smtpcs_pkg::ST_CLOSED)));
    plan.push_back(row(ROW_TYPED, smtpcs_pkg::OP_CONNECT, 10'd0, 1'b0, 1'b0, idle_init));
    plan.push_back(row(ROW_TYPED, smtpcs_pkg::OP_REPLY, 10'd999, 1'b1, 1'b1,
                       result(smtpcs_pkg::CMD_NONE, 4'd0, smtpcs_pkg::CLS_OTHER,
                              smtpcs_pkg::EV_UNEXPECTED, smtpcs_pkg::ST_CLOSED)));
    // drop in mid-session
    plan.push_back(row(ROW_TYPED, smtpcs_pkg::OP_CONNECT, 10'd0, 1'b0, 1'b0, idle_init));
    plan.push_back(row(ROW_TYPED, smtpcs_pkg::OP_CLOSE, 10'd0, 1'b0, 1'b0,
                       result(smtpcs_pkg::CMD_NONE, 4'd0, smtpcs_pkg::CLS_OTHER,
                              smtpcs_pkg::EV_CLOSED, smtpcs_pkg::ST_CLOSED)));
    // TLS handshake failure, with an unknown auth method and a zero recipient count
    plan.push_back(row(ROW_WRITE, smtpcs_pkg::REG_TLS_ENABLE, 10'd1, 1'b0, 1'b0, '0));
    plan.push_back(row(ROW_WRITE, smtpcs_pkg::REG_AUTH, 10'd3, 1'b0, 1'b0, '0));
    plan.push_back(row(ROW_WRITE, smtpcs_pkg::REG_RCPT_COUNT, 10'd0, 1'b0, 1'b0, '0));
    plan.push_back(row(ROW_PREDICTED, smtpcs_pkg::OP_CONNECT, 10'd0, 1'b0, 1'b0, '0));
    plan.push_back(row(ROW_PREDICTED, smtpcs_pkg::OP_REPLY, smtpcs_pkg::CODE_READY,
                       1'b1, 1'b1, '0));
    plan.push_back(row(ROW_PREDICTED, smtpcs_pkg::OP_REPLY, smtpcs_pkg::CODE_OK,
                       1'b1, 1'b1, '0));
    plan.push_back(row(ROW_TYPED, smtpcs_pkg::OP_REPLY, smtpcs_pkg::CODE_READY, 1'b1, 1'b0,
                       result(smtpcs_pkg::CMD_NONE, 4'd0, smtpcs_pkg::CLS_OTHER,
                              smtpcs_pkg::EV_TLS_FAIL, smtpcs_pkg::ST_CLOSED)));

    // Hold reset, then release it once
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (plan[i]) begin
      if (plan[i].kind == ROW_WRITE) begin
        drain();
        write_register(plan[i].op, plan[i].code[4:0]);
      end else begin
        r.operation     = plan[i].op;
        r.response_code = plan[i].code;
        r.final_line    = plan[i].last;
        r.tls_ok        = plan[i].tls_ok;
        send_request(r, plan[i].kind == ROW_TYPED, plan[i].want);
      end
    end

    // Random sessions: each phase starts idle, rewrites every register, then
    // runs under one idling pattern
    for (int phase = 0; phase < PHASES; phase++) begin
      drain();
      mode = phase % 4;
      sender_gap_pct = (mode == 1) ? 88 : (mode == 3) ? 12 : 0;
      sink_stall_pct = (mode == 2) ? 88 : (mode == 3) ? 12 : 0;
      if (phase < 6) begin
        write_register(smtpcs_pkg::REG_TLS_ENABLE, TLS_PLAN[phase]);
        write_register(smtpcs_pkg::REG_AUTH, AUTH_PLAN[phase]);
        write_register(smtpcs_pkg::REG_RCPT_COUNT, RCPT_PLAN[phase]);
      end else begin
        write_register(smtpcs_pkg::REG_TLS_ENABLE, 5'($urandom_range(31)));
        write_register(smtpcs_pkg::REG_AUTH, 5'($urandom_range(31)));
        write_register(smtpcs_pkg::REG_RCPT_COUNT, 5'($urandom_range(31)));
      end
      if (phase == 0) write_register(REG_UNUSED, 5'($urandom_range(31)));
      served = 0;
      while (served < PHASE_ITEMS) begin
        r = pick_request();
        // requests the block just ignores do not count toward the phase
        if (r.operation != OP_UNUSED &&
            !(r.operation == smtpcs_pkg::OP_REPLY && sess_state == smtpcs_pkg::ST_CLOSED))
        begin
          served++;
        end
        send_request(r, 1'b0, '0);
      end
    end

    drain();
    // let the two-stage pipe settle so a stray extra result would show up
    repeat (8) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
